@@ hdl/stsc_pkg.sv @@
// ----------------------------------------------------------------------------
// stsc_pkg
// Shared types and constants for the sparse triplet transpose block: port
// widths, register indexes, controller states and the command/status bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package stsc_pkg;

	// default sizing
	localparam int MAX_TERMS_DEF = 32;
	localparam int MAX_DIM_DEF   = 1024;

	// column indexes are 10 bits wide, so at most this many columns exist
	localparam int COL_SPAN = 1024;

	// field widths
	localparam int IDX_W  = 10;
	localparam int VAL_W  = 32;
	localparam int TRIP_W = 2 * IDX_W + VAL_W;
	localparam int DATA_W = 56;
	localparam int DIM_W  = 11;

	// configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS = 1'd1;

	// controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_EVAL,
		ST_DECIDE
	} stsc_state_t;

	// controller to datapath
	typedef struct packed {
		logic load;       // input transfer taken this cycle
		logic scan_init;  // start of the transpose sweep
		logic eval;       // judge the entry just read
		logic advance;    // take the winner of this scan as the next result
		logic finish;     // emit the closing result and empty the store
	} stsc_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic idx_done;   // scan index has reached the entry count
		logic found;      // this scan has a candidate
		logic pending;    // a result waits for its last flag
		logic out_free;   // output register can take a result
	} stsc_sts_t;

endpackage

`default_nettype wire

@@ hdl/sparse_transpose_symmetry_check_top.sv @@
// ----------------------------------------------------------------------------
// sparse_transpose_symmetry_check_top
// Sparse matrix triplet transpose with symmetry and overflow report.
// ----------------------------------------------------------------------------
// Triplets are loaded one per cycle into a store of MAX_TERMS entries; the
// transfer marked tlast starts the transpose, during which no input is taken.
// Each result is found by one scan of the n stored entries through a single
// read port of the store, so a run that emits k results takes k + 1 scans
// after the last input transfer; a stall on the output side holds a scan
// before it hands over its result. Results come in ascending original
// column order, ties in load order, with row and column swapped; entries
// whose column is not below num_cols or not below MAX_DIM are left out.
// The final result carries tlast, the symmetric flag and the overflow flag;
// when nothing is emitted a single closing result with tuser low is sent.
// ----------------------------------------------------------------------------
`default_nettype none

module sparse_transpose_symmetry_check_top #(
	parameter int MAX_TERMS = stsc_pkg::MAX_TERMS_DEF,
	parameter int MAX_DIM   = stsc_pkg::MAX_DIM_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// configuration writes
	input  wire logic                           cfg_we,
	input  wire logic [stsc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [stsc_pkg::DIM_W-1:0]     cfg_data,
	// triplet input
	input  wire logic                           s_axis_tvalid,
	output      logic                           s_axis_tready,
	input  wire logic [stsc_pkg::DATA_W-1:0]    s_axis_tdata,  // entry_row, entry_col, entry_value
	input  wire logic                           s_axis_tuser,  // entry_present
	input  wire logic                           s_axis_tlast,  // last_entry
	// transposed output
	output      logic                           m_axis_tvalid,
	input  wire logic                           m_axis_tready,
	output      logic [stsc_pkg::DATA_W-1:0]    m_axis_tdata,  // out_row, out_col, out_value,
	                                                           // is_symmetric, overflowed
	output      logic                           m_axis_tuser,  // out_present
	output      logic                           m_axis_tlast   // out_last
);

	import stsc_pkg::*;

	stsc_cmd_t cmd;
	stsc_sts_t sts;

	stsc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_last  (s_axis_tlast),
		.in_ready (s_axis_tready),
		.cmd      (cmd),
		.sts      (sts)
	);

	stsc_dpath #(
		.MAX_TERMS (MAX_TERMS),
		.MAX_DIM   (MAX_DIM)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_data     (s_axis_tdata),
		.in_present  (s_axis_tuser),
		.cmd         (cmd),
		.sts         (sts),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_data    (m_axis_tdata),
		.out_present (m_axis_tuser),
		.out_last    (m_axis_tlast)
	);

endmodule

`default_nettype wire

@@ hdl/stsc_ram.sv @@
// ----------------------------------------------------------------------------
// stsc_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module stsc_ram #(
	parameter int WIDTH = 52,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr_a,
	output      logic [WIDTH-1:0] rdata_a,
	input  wire logic [AW-1:0]    raddr_b,
	output      logic [WIDTH-1:0] rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read ports
	always_ff @(posedge clk) begin
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

`default_nettype wire

@@ hdl/stsc_ctrl.sv @@
// ----------------------------------------------------------------------------
// stsc_ctrl
// Controller: takes input transfers while idle, then runs one selection scan
// over the stored triplets per emitted result.
// ----------------------------------------------------------------------------
`default_nettype none

module stsc_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	input  wire logic                in_last,
	output      logic                in_ready,
	output      stsc_pkg::stsc_cmd_t cmd,
	input  wire stsc_pkg::stsc_sts_t sts
);

	import stsc_pkg::*;

	stsc_state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					if (in_last) begin
						cmd.scan_init = 1'b1;
						state_d       = ST_READ;
					end
				end
			end
			ST_READ: begin
				// read issued at the scan index; stop once all entries are seen
				if (sts.idx_done) begin
					state_d = ST_DECIDE;
				end else begin
					state_d = ST_EVAL;
				end
			end
			ST_EVAL: begin
				cmd.eval = 1'b1;
				state_d  = ST_READ;
			end
			ST_DECIDE: begin
				if (sts.found) begin
					if (!sts.pending || sts.out_free) begin
						cmd.advance = 1'b1;
						state_d     = ST_READ;
					end
				end else if (sts.out_free) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

`default_nettype wire

@@ hdl/stsc_dpath.sv @@
// ----------------------------------------------------------------------------
// stsc_dpath
// Datapath: configuration registers, triplet store, selection scan for the
// next (column, load order) entry, symmetry tracking and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module stsc_dpath #(
	parameter int MAX_TERMS = stsc_pkg::MAX_TERMS_DEF,
	parameter int MAX_DIM   = stsc_pkg::MAX_DIM_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [stsc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [stsc_pkg::DIM_W-1:0]          cfg_data,
	input  wire logic [stsc_pkg::DATA_W-1:0]         in_data,
	input  wire logic                                in_present,
	input  wire stsc_pkg::stsc_cmd_t                 cmd,
	output      stsc_pkg::stsc_sts_t                 sts,
	output      logic                                out_valid,
	input  wire logic                                out_ready,
	output      logic [stsc_pkg::DATA_W-1:0]         out_data,
	output      logic                                out_present,
	output      logic                                out_last
);

	import stsc_pkg::*;

	localparam int AW      = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
	localparam int CW      = $clog2(MAX_TERMS + 1);
	localparam int COL_CAP = (MAX_DIM < COL_SPAN) ? MAX_DIM : COL_SPAN;

	// configuration
	logic [DIM_W-1:0] num_rows_q, num_cols_q;

	// store bookkeeping
	logic [CW-1:0] count_q;
	logic          ovf_q;
	logic          full;

	// scan state
	logic [CW-1:0]    idx_q, k_q;
	logic             found_q, have_prev_q;
	logic [IDX_W-1:0] best_row_q, best_col_q;
	logic [VAL_W-1:0] best_val_q;
	logic [CW-1:0]    best_idx_q;
	logic [IDX_W-1:0] prev_col_q;
	logic [CW-1:0]    prev_idx_q;
	logic             sym_q;

	// result waiting for its last flag
	logic             pend_q;
	logic [IDX_W-1:0] pend_row_q, pend_col_q;
	logic [VAL_W-1:0] pend_val_q;

	// output register
	logic             out_valid_q;
	logic [DATA_W-1:0] out_data_q;
	logic             out_present_q, out_last_q;

	// store ports
	logic [TRIP_W-1:0] wdata, rd_a, rd_b;
	logic [IDX_W-1:0]  a_row, a_col, b_row, b_col;
	logic [VAL_W-1:0]  a_val, b_val;

	// scan decisions
	logic in_range, after_prev, better, take, match, sym_final, out_free;

	assign full  = (count_q == CW'(MAX_TERMS));
	assign wdata = in_data[TRIP_W-1:0];

	stsc_ram #(
		.WIDTH (TRIP_W),
		.DEPTH (MAX_TERMS)
	) u_store (
		.clk     (clk),
		.we      (cmd.load && in_present && !full),
		.waddr   (count_q[AW-1:0]),
		.wdata   (wdata),
		.raddr_a (idx_q[AW-1:0]),
		.rdata_a (rd_a),
		.raddr_b (k_q[AW-1:0]),
		.rdata_b (rd_b)
	);

	assign a_row = rd_a[IDX_W-1:0];
	assign a_col = rd_a[2*IDX_W-1:IDX_W];
	assign a_val = rd_a[TRIP_W-1:2*IDX_W];
	assign b_row = rd_b[IDX_W-1:0];
	assign b_col = rd_b[2*IDX_W-1:IDX_W];
	assign b_val = rd_b[TRIP_W-1:2*IDX_W];

	// candidate test for the entry just read
	always_comb begin
		in_range   = ({1'b0, a_col} < num_cols_q) && (32'(a_col) < 32'(COL_CAP));
		after_prev = !have_prev_q || (a_col > prev_col_q) ||
			((a_col == prev_col_q) && (idx_q > prev_idx_q));
		better     = !found_q || (a_col < best_col_q);
		take       = in_range && after_prev && better;
	end

	// stored entry at the emit position against the transposed winner
	assign match = (b_row == best_col_q) && (b_col == best_row_q) &&
		(b_val == best_val_q);

	assign sym_final = sym_q && (num_rows_q == num_cols_q) && (k_q == count_q);
	assign out_free  = !out_valid_q || out_ready;

	// status towards the controller
	always_comb begin
		sts.idx_done = (idx_q == count_q);
		sts.found    = found_q;
		sts.pending  = pend_q;
		sts.out_free = out_free;
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_rows_q <= DIM_W'(1);
			num_cols_q <= DIM_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_NUM_ROWS: num_rows_q <= cfg_data;
				REG_NUM_COLS: num_cols_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// control state of load and scan
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			ovf_q       <= 1'b0;
			idx_q       <= '0;
			k_q         <= '0;
			found_q     <= 1'b0;
			have_prev_q <= 1'b0;
			sym_q       <= 1'b1;
			pend_q      <= 1'b0;
		end else begin
			if (cmd.load && in_present) begin
				if (full) begin
					ovf_q <= 1'b1;
				end else begin
					count_q <= count_q + CW'(1);
				end
			end
			if (cmd.scan_init) begin
				idx_q       <= '0;
				k_q         <= '0;
				found_q     <= 1'b0;
				have_prev_q <= 1'b0;
				sym_q       <= 1'b1;
				pend_q      <= 1'b0;
			end
			if (cmd.eval) begin
				idx_q <= idx_q + CW'(1);
				if (take) begin
					found_q <= 1'b1;
				end
			end
			if (cmd.advance) begin
				idx_q       <= '0;
				k_q         <= k_q + CW'(1);
				found_q     <= 1'b0;
				have_prev_q <= 1'b1;
				pend_q      <= 1'b1;
				if (!match) begin
					sym_q <= 1'b0;
				end
			end
			if (cmd.finish) begin
				count_q <= '0;
				ovf_q   <= 1'b0;
				pend_q  <= 1'b0;
			end
		end
	end

	// scan payload
	always_ff @(posedge clk) begin
		if (cmd.eval && take) begin
			best_row_q <= a_row;
			best_col_q <= a_col;
			best_val_q <= a_val;
			best_idx_q <= idx_q;
		end
		if (cmd.advance) begin
			prev_col_q <= best_col_q;
			prev_idx_q <= best_idx_q;
			pend_row_q <= best_row_q;
			pend_col_q <= best_col_q;
			pend_val_q <= best_val_q;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((cmd.advance && pend_q) || cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload: former column becomes the row
	always_ff @(posedge clk) begin
		if (cmd.advance && pend_q) begin
			out_data_q    <= {2'd0, 1'b0, 1'b0, pend_val_q, pend_row_q, pend_col_q};
			out_present_q <= 1'b1;
			out_last_q    <= 1'b0;
		end else if (cmd.finish) begin
			out_last_q <= 1'b1;
			if (pend_q) begin
				out_data_q    <= {2'd0, ovf_q, sym_final, pend_val_q, pend_row_q,
					pend_col_q};
				out_present_q <= 1'b1;
			end else begin
				// nothing to emit: a bare closing result
				out_data_q    <= {2'd0, ovf_q, sym_final, {TRIP_W{1'b0}}};
				out_present_q <= 1'b0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign out_data    = out_data_q;
	assign out_present = out_present_q;
	assign out_last    = out_last_q;

endmodule

`default_nettype wire

@@ sim/tb_sparse_transpose_symmetry_check_top.sv @@
// ----------------------------------------------------------------------------
// tb_sparse_transpose_symmetry_check_top
// Self-checking bench for the sparse triplet transpose block. A queue of
// triplet transfers feeds a clocked driver. A clocked monitor compares every
// output transfer, field by field, against a transpose predictor kept in the
// bench. A short directed set comes first: dimension extremes, empty runs,
// symmetric runs, out-of-range columns and rows. Random runs follow:
// symmetric matrices (some of them corrupted), general matrices, overflowing
// loads and short runs. Source gaps and sink stalls change from phase to phase.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_sparse_transpose_symmetry_check_top;

	import stsc_pkg::*;

	localparam int MAX_TERMS     = MAX_TERMS_DEF;
	localparam int MAX_DIM       = MAX_DIM_DEF;
	localparam int RANDOM_ITEMS  = 460;
	localparam int SETTLE_CYCLES = 2 * MAX_TERMS + 16;

	// one triplet transfer on the input side
	typedef struct {
		logic [IDX_W-1:0] row;
		logic [IDX_W-1:0] col;
		logic [VAL_W-1:0] value;
		logic             present;
		logic             is_last;
	} entry_t;

	// one transposed triplet on the output side
	typedef struct {
		logic [IDX_W-1:0] row;
		logic [IDX_W-1:0] col;
		logic [VAL_W-1:0] value;
		logic             present;
		logic             is_last;
		logic             symmetric;
		logic             overflow;
	} transposed_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_NUM_ROWS;
	logic [DIM_W-1:0]     cfg_data = '0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [DATA_W-1:0]    s_axis_tdata = '0;
	logic                 s_axis_tuser = 1'b0;
	logic                 s_axis_tlast = 1'b0;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [DATA_W-1:0]    m_axis_tdata;
	logic                 m_axis_tuser;
	logic                 m_axis_tlast;

	entry_t      pending_entries[$];
	transposed_t expected_triplets[$];

	// bench copy of the block state and registers
	logic [IDX_W-1:0] held_row [MAX_TERMS];
	logic [IDX_W-1:0] held_col [MAX_TERMS];
	logic [VAL_W-1:0] held_val [MAX_TERMS];
	int               held_count = 0;
	logic             held_overflow = 1'b0;
	logic [DIM_W-1:0] cfg_rows = 1;
	logic [DIM_W-1:0] cfg_cols = 1;

	int error_count = 0;
	int src_idle_pct = 0;
	int snk_stall_pct = 0;
	int random_count = 0;

	sparse_transpose_symmetry_check_top uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	// clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t ns: %s mismatch: got %0h, expected %0h", $time, what, got, want);
		error_count++;
	endtask

	// store a triplet and, on the last transfer, build the transposed list
	task automatic transpose_predict(input entry_t e);
		logic [IDX_W-1:0] t_row [MAX_TERMS];
		logic [IDX_W-1:0] t_col [MAX_TERMS];
		logic [VAL_W-1:0] t_val [MAX_TERMS];
		int               limit;
		int               k;
		int               c;
		int               i;
		logic             sym;
		transposed_t      r;
		if (e.present) begin
			if (held_count < MAX_TERMS) begin
				held_row[held_count] = e.row;
				held_col[held_count] = e.col;
				held_val[held_count] = e.value;
				held_count++;
			end else begin
				held_overflow = 1'b1;
			end
		end
		if (!e.is_last)
			return;
		limit = (cfg_cols > MAX_DIM) ? MAX_DIM : int'(cfg_cols);
		k = 0;
		// ascending column, ties in load order
		for (c = 0; c < limit; c++) begin
			for (i = 0; i < held_count; i++) begin
				if (held_col[i] == c && k < MAX_TERMS) begin
					t_row[k] = held_col[i];
					t_col[k] = held_row[i];
					t_val[k] = held_val[i];
					k++;
				end
			end
		end
		sym = (cfg_rows == cfg_cols) && (k == held_count);
		for (i = 0; sym && i < held_count; i++) begin
			if (held_row[i] != t_row[i] || held_col[i] != t_col[i] || held_val[i] != t_val[i])
				sym = 1'b0;
		end
		if (k == 0) begin
			r = '{row: '0, col: '0, value: '0, present: 1'b0, is_last: 1'b1,
				symmetric: sym, overflow: held_overflow};
			expected_triplets.push_back(r);
		end else begin
			for (i = 0; i < k; i++) begin
				r.row       = t_row[i];
				r.col       = t_col[i];
				r.value     = t_val[i];
				r.present   = 1'b1;
				r.is_last   = (i == k - 1);
				r.symmetric = r.is_last && sym;
				r.overflow  = r.is_last && held_overflow;
				expected_triplets.push_back(r);
			end
		end
		held_count    = 0;
		held_overflow = 1'b0;
	endtask

	// input driver: take the accepted transfer, then load the next one
	always @(posedge clk) begin
		entry_t e;
		if (s_axis_tvalid && s_axis_tready) begin
			e.row     = s_axis_tdata[IDX_W-1:0];
			e.col     = s_axis_tdata[2*IDX_W-1:IDX_W];
			e.value   = s_axis_tdata[TRIP_W-1:2*IDX_W];
			e.present = s_axis_tuser;
			e.is_last = s_axis_tlast;
			transpose_predict(e);
		end
		if (!s_axis_tvalid || s_axis_tready) begin
			if (arst_n && pending_entries.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
				e = pending_entries.pop_front();
				s_axis_tdata  <= {{(DATA_W-TRIP_W){1'b0}}, e.value, e.col, e.row};
				s_axis_tuser  <= e.present;
				s_axis_tlast  <= e.is_last;
				s_axis_tvalid <= 1'b1;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// output monitor and sink stalls
	always @(posedge clk) begin
		transposed_t want;
		if (m_axis_tvalid && m_axis_tready) begin
			if (expected_triplets.size() == 0) begin
				report_mismatch("unexpected result", m_axis_tdata[31:0], 32'h0);
			end else begin
				want = expected_triplets.pop_front();
				if (m_axis_tdata[IDX_W-1:0] != want.row)
					report_mismatch("out_row", 32'(m_axis_tdata[IDX_W-1:0]),
						32'(want.row));
				if (m_axis_tdata[2*IDX_W-1:IDX_W] != want.col)
					report_mismatch("out_col", 32'(m_axis_tdata[2*IDX_W-1:IDX_W]),
						32'(want.col));
				if (m_axis_tdata[TRIP_W-1:2*IDX_W] != want.value)
					report_mismatch("out_value", m_axis_tdata[TRIP_W-1:2*IDX_W], want.value);
				if (m_axis_tdata[TRIP_W] != want.symmetric)
					report_mismatch("is_symmetric", 32'(m_axis_tdata[TRIP_W]),
						32'(want.symmetric));
				if (m_axis_tdata[TRIP_W+1] != want.overflow)
					report_mismatch("overflowed", 32'(m_axis_tdata[TRIP_W+1]),
						32'(want.overflow));
				if (m_axis_tuser != want.present)
					report_mismatch("out_present", 32'(m_axis_tuser), 32'(want.present));
				if (m_axis_tlast != want.is_last)
					report_mismatch("out_last", 32'(m_axis_tlast), 32'(want.is_last));
			end
		end
		m_axis_tready <= arst_n && ($urandom_range(99) >= snk_stall_pct);
	end

	task automatic push_entry(input int row, input int col, input logic [VAL_W-1:0] value,
			input logic present, input logic is_last);
		entry_t e;
		e.row     = IDX_W'(row);
		e.col     = IDX_W'(col);
		e.value   = value;
		e.present = present;
		e.is_last = is_last;
		pending_entries.push_back(e);
	endtask

	// wait until every transfer is in and every result is out, then let it settle
	task automatic wait_idle();
		do
			@(negedge clk);
		while (pending_entries.size() != 0 || s_axis_tvalid || expected_triplets.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input int data);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= DIM_W'(data);
		@(posedge clk);
		cfg_we    <= 1'b0;
		if (idx == REG_NUM_ROWS)
			cfg_rows = DIM_W'(data);
		else
			cfg_cols = DIM_W'(data);
		@(negedge clk);
	endtask

	task automatic set_dims(input int rows, input int cols);
		wait_idle();
		write_register(REG_NUM_ROWS, rows);
		write_register(REG_NUM_COLS, cols);
	endtask

	function automatic int pick_dim();
		case ($urandom_range(9))
			0: return 0;
			1: return 1;
			2: return MAX_DIM;
			3: return $urandom_range(MAX_DIM + 1, 2047);
			4: return 2047;
			default: return $urandom_range(2, 16);
		endcase
	endfunction

	function automatic logic [VAL_W-1:0] pick_value();
		case ($urandom_range(19))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'h0;
			3: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	// close a run: either flag the final transfer or add an empty closing one
	task automatic close_run();
		if (pending_entries.size() != 0 && $urandom_range(99) < 70)
			pending_entries[$].is_last = 1'b1;
		else
			push_entry(0, 0, '0, 1'b0, 1'b1);
	endtask

	// symmetric matrix loaded in row-major order, optionally with one value spoiled
	task automatic queue_symmetric_run(input int dim, input bit spoil);
		logic [VAL_W-1:0] cells [int];
		logic [VAL_W-1:0] v;
		int               r;
		int               c;
		int               pick;
		int               n;
		repeat ($urandom_range(1, 10)) begin
			r = $urandom_range(dim - 1);
			c = $urandom_range(dim - 1);
			v = pick_value();
			cells[r * COL_SPAN + c] = v;
			cells[c * COL_SPAN + r] = v;
		end
		pick = spoil ? $urandom_range(cells.num() - 1) : -1;
		n = 0;
		foreach (cells[key]) begin
			if ($urandom_range(99) < 5)
				push_entry($urandom_range(1023), $urandom_range(1023), $urandom, 1'b0, 1'b0);
			v = cells[key];
			if (n == pick)
				v = v ^ (32'h1 << $urandom_range(31));
			push_entry(key / COL_SPAN, key % COL_SPAN, v, 1'b1, 1'b0);
			n++;
		end
		random_count += n;
		close_run();
	endtask

	// general matrix, indexes mostly near the configured size
	task automatic queue_general_run(input int n);
		int span;
		int row;
		int col;
		logic present;
		span = (cfg_cols + 1 > 1023) ? 1023 : int'(cfg_cols) + 1;
		repeat (n) begin
			row = ($urandom_range(1) == 0) ? $urandom_range(span) : $urandom_range(1023);
			col = ($urandom_range(1) == 0) ? $urandom_range(span) : $urandom_range(1023);
			present = ($urandom_range(99) < 90);
			push_entry(row, col, pick_value(), present, 1'b0);
			if (present)
				random_count++;
		end
		close_run();
	endtask

	// stimulus
	initial begin
		int phase;
		int kind;
		int dim;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// single diagonal entry under the reset dimensions
		push_entry(0, 0, 32'h1, 1'b1, 1'b1);
		set_dims(4, 4);
		// empty matrix
		push_entry(0, 0, '0, 1'b0, 1'b1);
		// symmetric off-diagonal pair plus diagonal
		push_entry(0, 1, -32'sd5, 1'b1, 1'b0);
		push_entry(1, 0, -32'sd5, 1'b1, 1'b0);
		push_entry(2, 2, 32'h7FFF_FFFF, 1'b1, 1'b1);
		// unordered load, column outside the matrix, row outside the matrix,
		// an item with no element, closing item with no element
		push_entry(3, 2, 32'h7, 1'b1, 1'b0);
		push_entry(0, 1, 32'h8000_0000, 1'b1, 1'b0);
		push_entry(1, 5, 32'h3, 1'b1, 1'b0);
		push_entry(900, 0, 32'hFFFF_FFFF, 1'b1, 1'b0);
		push_entry(0, 0, 32'h0, 1'b0, 1'b0);
		push_entry(2, 3, 32'h0, 1'b0, 1'b1);
		// largest matrix, corner indexes
		set_dims(MAX_DIM, MAX_DIM);
		push_entry(1023, 1023, 32'h7FFF_FFFF, 1'b1, 1'b0);
		push_entry(0, 1023, 32'h8000_0000, 1'b1, 1'b0);
		push_entry(1023, 0, 32'h8000_0000, 1'b1, 1'b1);
		// zero columns: nothing can be emitted
		set_dims(0, 0);
		push_entry(5, 0, 32'h1, 1'b1, 1'b1);
		// dimensions above the column span
		set_dims(2047, 2047);
		push_entry(1023, 1023, 32'hFFFF_FFFF, 1'b1, 1'b1);
		// non-square matrix
		set_dims(3, 5);
		push_entry(1, 1, 32'h2, 1'b1, 1'b1);

		// random runs
		while (random_count < RANDOM_ITEMS) begin
			phase = random_count * 4 / RANDOM_ITEMS;
			case (phase)
				0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
				1: begin src_idle_pct = 82; snk_stall_pct = 0;  end
				2: begin src_idle_pct = 0;  snk_stall_pct = 82; end
				default: begin src_idle_pct = 29; snk_stall_pct = 29; end
			endcase
			kind = $urandom_range(99);
			if (kind < 35) begin
				case ($urandom_range(19))
					0, 1, 2: dim = MAX_DIM;
					3, 4, 5: dim = $urandom_range(9, 1023);
					default: dim = $urandom_range(1, 8);
				endcase
				if (cfg_rows != dim || cfg_cols != dim)
					set_dims(dim, dim);
				queue_symmetric_run(dim, $urandom_range(99) < 20);
			end else begin
				if ($urandom_range(99) < 30) begin
					dim = pick_dim();
					set_dims(($urandom_range(1) == 0) ? dim : pick_dim(), dim);
				end
				if (kind < 60)
					queue_general_run($urandom_range(0, 20));
				else if (kind < 72)
					queue_general_run($urandom_range(30, 40));
				else
					queue_general_run($urandom_range(0, 3));
			end
			// let the queue drain now and then so runs do not always overlap
			if ($urandom_range(99) < 20)
				wait_idle();
		end

		wait_idle();
		if (error_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// watchdog
	initial begin
		#10_000_000;
		$display("Some tests failed");
		$finish;
	end

endmodule
